@@ sv/tabl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabl_pkg
// shared constants, types and helpers for the trimmed brightness filter
// ----------------------------------------------------------------------------
package tabl_pkg;

    // window of samples averaged per result
    localparam int WINDOW   = 10;
    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W  = 4;
    localparam int CFG_IDX_W = 2;

    // full window sum width and trimmed divisor
    localparam int SUM_W   = $clog2(WINDOW * 4095 + 1);
    localparam int DIVISOR = WINDOW - 2;
    localparam int CNT_W   = $clog2(WINDOW);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL3 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL5 = 2'd3;

    // limit values after reset
    localparam logic [SAMPLE_W-1:0] LIMIT1_RST = 12'd200;
    localparam logic [SAMPLE_W-1:0] LIMIT2_RST = 12'd500;
    localparam logic [SAMPLE_W-1:0] LIMIT3_RST = 12'd1000;
    localparam logic [SAMPLE_W-1:0] LIMIT5_RST = 12'd2000;

    // brightness level codes
    localparam logic [LEVEL_W-1:0] LVL_1 = 4'd1;
    localparam logic [LEVEL_W-1:0] LVL_2 = 4'd2;
    localparam logic [LEVEL_W-1:0] LVL_3 = 4'd3;
    localparam logic [LEVEL_W-1:0] LVL_5 = 4'd5;
    localparam logic [LEVEL_W-1:0] LVL_8 = 4'd8;

    // accumulator controls from the sequencer
    typedef struct packed {
        logic clear;
        logic add;
    } t_acc_ctrl;

    // first limit the value lies below wins, tested in fixed order
    function automatic logic [LEVEL_W-1:0] pick_level(
        input logic [SAMPLE_W-1:0] v,
        input logic [SAMPLE_W-1:0] l1,
        input logic [SAMPLE_W-1:0] l2,
        input logic [SAMPLE_W-1:0] l3,
        input logic [SAMPLE_W-1:0] l5
    );
        logic [LEVEL_W-1:0] lvl;
        if (v < l1) begin
            lvl = LVL_1;
        end else if (v < l2) begin
            lvl = LVL_2;
        end else if (v < l3) begin
            lvl = LVL_3;
        end else if (v < l5) begin
            lvl = LVL_5;
        end else begin
            lvl = LVL_8;
        end
        return lvl;
    endfunction

endpackage

@@ sv/trimmed_average_brightness_level.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_average_brightness_level
// trimmed moving average of light samples with a brightness level lookup
// ----------------------------------------------------------------------------
// a request walks the sample chain, one cell a cycle, then the three-stage
//   divider; no new request is taken until the result has moved to the
//   output register
// a finished result waits in the output register while the next request enters
// reset (synchronous, active low) clears the window to zeros, the sequencer
//   and output valid, and loads the default level limits
module trimmed_average_brightness_level (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // sample requests
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [tabl_pkg::SAMPLE_W-1:0]  i_light_sample,
    // results
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [tabl_pkg::SAMPLE_W-1:0]  o_filtered_value,
    output logic [tabl_pkg::LEVEL_W-1:0]   o_brightness_level,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [tabl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tabl_pkg::SAMPLE_W-1:0]  i_cfg_data
);
    import tabl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_div_start;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_filtered;
    logic [LEVEL_W-1:0]  r_level;

    logic [SAMPLE_W-1:0] r_lim1;
    logic [SAMPLE_W-1:0] r_lim2;
    logic [SAMPLE_W-1:0] r_lim3;
    logic [SAMPLE_W-1:0] r_lim5;

    logic                w_accept;
    logic                w_out_free;
    logic                w_cell_en;
    logic [SAMPLE_W-1:0] w_cell_q [WINDOW];
    logic [SAMPLE_W-1:0] w_head_d;
    t_acc_ctrl           w_acc_ctrl;
    logic [SUM_W-1:0]    w_trimmed;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_quot;

    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // level limits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim1 <= LIMIT1_RST;
            r_lim2 <= LIMIT2_RST;
            r_lim3 <= LIMIT3_RST;
            r_lim5 <= LIMIT5_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVEL1: r_lim1 <= i_cfg_data;
                CFG_LEVEL2: r_lim2 <= i_cfg_data;
                CFG_LEVEL3: r_lim3 <= i_cfg_data;
                CFG_LEVEL5: r_lim5 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sample chain
    // a request shifts the new sample in at the head and drops the oldest;
    // during the scan the chain rotates, tail back to head, so every sample
    // passes the tail once and the chain ends in its starting order
    // ------------------------------------------------------------------
    assign w_cell_en = w_accept || (r_state == S_SCAN);
    assign w_head_d  = (r_state == S_IDLE) ? i_light_sample : w_cell_q[WINDOW-1];

    tabl_cell u_cell_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_cell_en),
        .i_d     (w_head_d),
        .o_q     (w_cell_q[0])
    );

    for (genvar g = 1; g < WINDOW; g++) begin : g_cell
        tabl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_cell_en),
            .i_d     (w_cell_q[g-1]),
            .o_q     (w_cell_q[g])
        );
    end

    // ------------------------------------------------------------------
    // sum, max and min of the tail as it goes by
    // ------------------------------------------------------------------
    assign w_acc_ctrl.clear = w_accept;
    assign w_acc_ctrl.add   = (r_state == S_SCAN);

    tabl_accum u_accum (
        .i_clk     (i_clk),
        .i_ctrl    (w_acc_ctrl),
        .i_sample  (w_cell_q[WINDOW-1]),
        .o_trimmed (w_trimmed)
    );

    // divider start is registered together with the last add, so it reads the finished sum
    tabl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (w_trimmed),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // ------------------------------------------------------------------
    // sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(WINDOW - 1)) begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        // straight out when the slot is free, else hold
                        if (w_out_free) begin
                            r_out_valid <= 1'b1;
                            r_filtered  <= w_quot;
                            r_level     <= pick_level(w_quot, r_lim1, r_lim2,
                                                      r_lim3, r_lim5);
                            r_state     <= S_IDLE;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_filtered  <= w_quot;
                        r_level     <= pick_level(w_quot, r_lim1, r_lim2,
                                                  r_lim3, r_lim5);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready            = (r_state == S_IDLE);
    assign o_valid            = r_out_valid;
    assign o_filtered_value   = r_filtered;
    assign o_brightness_level = r_level;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_SCAN && r_cnt == '0))
        else $error("request did not start a fresh scan");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= CNT_W'(WINDOW - 1)))
        else $error("scan count ran past the window");

    a_done_while_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_start_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_div_start) |-> $past(r_state == S_SCAN))
        else $error("divider started without a finished scan");

    a_level_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_level == LVL_1 || r_level == LVL_2 || r_level == LVL_3
                         || r_level == LVL_5 || r_level == LVL_8))
        else $error("brightness level is not a legal code");

endmodule

@@ sv/tabl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabl_cell
// one sample slot of the window chain, loads its neighbor when enabled
// ----------------------------------------------------------------------------
module tabl_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [tabl_pkg::SAMPLE_W-1:0] i_d,
    output logic [tabl_pkg::SAMPLE_W-1:0] o_q
);
    import tabl_pkg::*;

    logic [SAMPLE_W-1:0] r_q;

    // window starts out cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ sv/tabl_accum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabl_accum
// running sum, maximum and minimum of the samples passing the chain tail
// ----------------------------------------------------------------------------
module tabl_accum (
    input  logic                          i_clk,
    input  tabl_pkg::t_acc_ctrl           i_ctrl,
    input  logic [tabl_pkg::SAMPLE_W-1:0] i_sample,
    output logic [tabl_pkg::SUM_W-1:0]    o_trimmed
);
    import tabl_pkg::*;

    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_max;
    logic [SAMPLE_W-1:0] r_min;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_sum <= '0;
            r_max <= '0;
            r_min <= '1;
        end else if (i_ctrl.add) begin
            r_sum <= r_sum + SUM_W'(i_sample);
            if (i_sample > r_max) begin
                r_max <= i_sample;
            end
            if (i_sample < r_min) begin
                r_min <= i_sample;
            end
        end
    end

    // one max and one min dropped
    assign o_trimmed = r_sum - SUM_W'(r_max) - SUM_W'(r_min);

endmodule

@@ sv/tabl_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabl_div
// divide by the trimmed window size: reciprocal multiply, then one correction
// ----------------------------------------------------------------------------
module tabl_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tabl_pkg::SUM_W-1:0]    i_num,
    output logic                          o_done,
    output logic [tabl_pkg::SAMPLE_W-1:0] o_quot
);
    import tabl_pkg::*;

    localparam int PROD_W = 2 * SUM_W + 1;
    localparam logic [SUM_W:0]   RECIP = (SUM_W + 1)'((2 ** SUM_W) / DIVISOR);
    localparam logic [SUM_W-1:0] DIV_V = SUM_W'(DIVISOR);

    logic [2:0]          r_v;
    logic [SUM_W-1:0]    r_num;
    logic [SUM_W-1:0]    r_num2;
    logic [SAMPLE_W-1:0] r_q0;
    logic [SAMPLE_W-1:0] r_q;

    logic [PROD_W-1:0]   w_prod;
    logic [SUM_W-1:0]    w_rem;

    // estimate is exact or one low
    assign w_prod = PROD_W'(r_num) * PROD_W'(RECIP);
    assign w_rem  = r_num2 - SUM_W'(SUM_W'(r_q0) * DIV_V);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end
        if (r_v[0]) begin
            r_q0   <= w_prod[SUM_W+SAMPLE_W-1:SUM_W];
            r_num2 <= r_num;
        end
        if (r_v[1]) begin
            r_q <= (w_rem >= DIV_V) ? r_q0 + SAMPLE_W'(1) : r_q0;
        end
    end

    assign o_done = r_v[2];
    assign o_quot = r_q;

endmodule

@@ dv/trimmed_average_brightness_level_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_average_brightness_level_tb
// self-checking bench for the trimmed light average and brightness lookup:
// a queue-fed driver sends light samples, an internal window model predicts
// each filtered value and level, and a monitor compares every result in order
// while the level limits are rewritten between idle phases
// ----------------------------------------------------------------------------
module trimmed_average_brightness_level_tb;

    import tabl_pkg::*;

    // one predicted or observed result
    typedef struct packed {
        logic [SAMPLE_W-1:0] filtered;
        logic [LEVEL_W-1:0]  level;
    } t_light_result;

    // clock, reset and block ports; the driven ones are known from time zero
    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_valid            = 1'b0;
    logic                 o_ready;
    logic [SAMPLE_W-1:0]  i_light_sample     = '0;
    logic                 o_valid;
    logic                 i_ready            = 1'b0;
    logic [SAMPLE_W-1:0]  o_filtered_value;
    logic [LEVEL_W-1:0]   o_brightness_level;
    logic                 i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx          = CFG_LEVEL1;
    logic [SAMPLE_W-1:0]  i_cfg_data         = '0;

    // samples waiting to be sent and results waiting to be seen
    logic [SAMPLE_W-1:0]  pending_samples[$];
    t_light_result        expected_results[$];

    // model copy of the sample window, write pointer and level limits
    logic [SAMPLE_W-1:0]  window_copy [WINDOW];
    int unsigned          next_slot = 0;
    logic [SAMPLE_W-1:0]  level_limit [4];

    // when set, neither side idles
    bit                   steady     = 1'b0;
    int unsigned          fail_count = 0;

    always #5 i_clk = ~i_clk;

    trimmed_average_brightness_level dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_light_sample     (i_light_sample),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_filtered_value   (o_filtered_value),
        .o_brightness_level (o_brightness_level),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    // store one sample in the window, then sum it, drop one max and one min,
    // divide by the trimmed count and look up the level
    function automatic t_light_result trimmed_brightness(input logic [SAMPLE_W-1:0] sample);
        t_light_result r;
        int unsigned   total;
        int unsigned   peak;
        int unsigned   low_v;
        int unsigned   avg;
        window_copy[next_slot] = sample;
        next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
        total = 0;
        peak  = 0;
        low_v = 4095;
        for (int k = 0; k < WINDOW; k++) begin
            total += window_copy[k];
            if (window_copy[k] > peak) begin
                peak = window_copy[k];
            end
            if (window_copy[k] < low_v) begin
                low_v = window_copy[k];
            end
        end
        // ties drop just one entry each, so plain subtraction does it
        avg = (total - peak - low_v) / (WINDOW - 2);
        r.filtered = SAMPLE_W'(avg);
        // fixed test order, whatever the limits look like
        if (r.filtered < level_limit[CFG_LEVEL1]) begin
            r.level = LVL_1;
        end else if (r.filtered < level_limit[CFG_LEVEL2]) begin
            r.level = LVL_2;
        end else if (r.filtered < level_limit[CFG_LEVEL3]) begin
            r.level = LVL_3;
        end else if (r.filtered < level_limit[CFG_LEVEL5]) begin
            r.level = LVL_5;
        end else begin
            r.level = LVL_8;
        end
        return r;
    endfunction

    // driver: holds a request until accepted, idles at random otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(trimmed_brightness(i_light_sample));
            end
            // slot is free once the current request is taken or none is out
            if (!i_valid || o_ready) begin
                if (pending_samples.size() > 0 && (steady || $urandom_range(0, 99) >= 34)) begin
                    i_valid        <= 1'b1;
                    i_light_sample <= pending_samples.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random back-pressure, in-order field compare
    always @(posedge i_clk) begin : result_check
        t_light_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected result: filtered %0d level %0d",
                             o_filtered_value, o_brightness_level);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_filtered_value !== want.filtered
                        || o_brightness_level !== want.level) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: filtered exp %0d got %0d, level exp %0d got %0d",
                                 want.filtered, o_filtered_value,
                                 want.level, o_brightness_level);
                    end
                end
            end
        end
        i_ready <= steady || ($urandom_range(0, 99) >= 34);
    end

    // one register write per cycle; caller drops the enable afterwards
    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        level_limit[idx] = val;
    endtask

    task automatic set_limits(input logic [SAMPLE_W-1:0] l1, input logic [SAMPLE_W-1:0] l2,
                              input logic [SAMPLE_W-1:0] l3, input logic [SAMPLE_W-1:0] l5);
        write_limit(CFG_LEVEL1, l1);
        write_limit(CFG_LEVEL2, l2);
        write_limit(CFG_LEVEL3, l3);
        write_limit(CFG_LEVEL5, l5);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // waits until every queued sample is sent and has its result back
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_samples.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    // random samples in chunks: full range, clustered, rail-to-rail, dim
    task automatic queue_random(input int count);
        int mode;
        int center;
        int spread;
        int s;
        mode   = 0;
        center = 0;
        spread = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 10 == 0) begin
                mode   = $urandom_range(0, 3);
                center = (mode == 3) ? $urandom_range(0, 600) : $urandom_range(0, 4095);
                spread = $urandom_range(0, 80);
            end
            case (mode)
                0: s = $urandom_range(0, 4095);
                2: s = ($urandom_range(0, 1) != 0) ? 4095 : 0;
                default: s = center - spread + $urandom_range(0, 2 * spread);
            endcase
            if (s < 0) begin
                s = 0;
            end else if (s > 4095) begin
                s = 4095;
            end
            pending_samples.push_back(SAMPLE_W'(s));
        end
    endtask

    // stimulus and phase control
    initial begin : phase_control
        int a;
        int b;
        int c;
        int d;
        for (int k = 0; k < WINDOW; k++) begin
            window_copy[k] = '0;
        end
        level_limit[CFG_LEVEL1] = LIMIT1_RST;
        level_limit[CFG_LEVEL2] = LIMIT2_RST;
        level_limit[CFG_LEVEL3] = LIMIT3_RST;
        level_limit[CFG_LEVEL5] = LIMIT5_RST;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, default limits: zero-filled start against full scale,
        // a full window of equal maxima, then the minimum ties
        repeat (10) pending_samples.push_back(12'd4095);
        repeat (2) pending_samples.push_back(12'd0);
        // walking one touches every sample bit
        for (int k = 0; k < SAMPLE_W; k++) begin
            pending_samples.push_back(SAMPLE_W'(1) << k);
        end
        pending_samples.push_back(12'hAAA);
        pending_samples.push_back(12'h555);
        wait_drained();

        // all limits zero: everything lands on the top level
        set_limits(12'd0, 12'd0, 12'd0, 12'd0);
        queue_random(40);
        wait_drained();

        // all limits at full scale: level 1 unless the average saturates
        set_limits(12'd4095, 12'd4095, 12'd4095, 12'd4095);
        repeat (10) pending_samples.push_back(12'd4095);
        queue_random(30);
        wait_drained();

        // limits out of order: first one the value lies below still wins
        set_limits(12'd1500, 12'd800, 12'd3000, 12'd2500);
        queue_random(60);
        wait_drained();

        // long stretch with no idling on either side
        set_limits(12'd300, 12'd900, 12'd1800, 12'd3000);
        steady = 1'b1;
        queue_random(150);
        wait_drained();
        steady = 1'b0;

        // random settings, mostly ascending, sometimes shuffled
        for (int p = 0; p < 4; p++) begin
            a = $urandom_range(0, 1200);
            b = a + $urandom_range(0, 900);
            c = b + $urandom_range(0, 900);
            d = c + $urandom_range(0, 1000);
            if (p == 3) begin
                set_limits(SAMPLE_W'(d), SAMPLE_W'(a), SAMPLE_W'(c), SAMPLE_W'(b));
            end else begin
                set_limits(SAMPLE_W'(a), SAMPLE_W'(b), SAMPLE_W'(c), SAMPLE_W'(d));
            end
            queue_random(60);
            wait_drained();
        end

        // back to the reset limits
        set_limits(LIMIT1_RST, LIMIT2_RST, LIMIT3_RST, LIMIT5_RST);
        queue_random(60);
        wait_drained();

        // let any stray result show up
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("trimmed_average_brightness_level test passed");
        end else begin
            $display("trimmed_average_brightness_level test failed");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("trimmed_average_brightness_level test failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/tabl_pkg.sv
sv/tabl_cell.sv
sv/tabl_accum.sv
sv/tabl_div.sv
sv/trimmed_average_brightness_level.sv
dv/trimmed_average_brightness_level_tb.sv
